FILE: src/itaf_pkg.sv
`default_nettype none
package itaf_pkg;

  // One more than the longest text that one number may produce, sign and prefix included.
  localparam int MAX_CHARS = 64;
  localparam int CNT_W = $clog2(MAX_CHARS);
  localparam int WIDTH_CAP = MAX_CHARS - 1;
  localparam int PREC_CAP = MAX_CHARS - 4;

  localparam int VAL_W = 64;
  localparam int MAX_DIGITS = 22;
  localparam int ND_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int BCD_DIGITS = 20;
  localparam int WORK_W = 4 * BCD_DIGITS;
  localparam int DCNT_W = $clog2(VAL_W);
  localparam int IN_W = 88;

  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;

  localparam int FLAG_ZPAD = 0;
  localparam int FLAG_SIGNED = 1;
  localparam int FLAG_PLUS = 2;
  localparam int FLAG_SPACE = 3;
  localparam int FLAG_LEFT = 4;
  localparam int FLAG_PREFIX = 5;
  localparam int FLAG_UPPER = 6;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X = 8'h58;

  // Micro-operations.
  localparam logic [2:0] OP_WAIT = 3'd0;
  localparam logic [2:0] OP_PREP = 3'd1;
  localparam logic [2:0] OP_DABBLE = 3'd2;
  localparam logic [2:0] OP_EXTRACT = 3'd3;
  localparam logic [2:0] OP_LAYOUT = 3'd4;
  localparam logic [2:0] OP_EMIT = 3'd5;

  // Character sources of the emit steps.
  localparam logic [2:0] SRC_LSP = 3'd0;
  localparam logic [2:0] SRC_SIGN = 3'd1;
  localparam logic [2:0] SRC_PRE0 = 3'd2;
  localparam logic [2:0] SRC_PREX = 3'd3;
  localparam logic [2:0] SRC_ZPAD = 3'd4;
  localparam logic [2:0] SRC_PREC = 3'd5;
  localparam logic [2:0] SRC_DIG = 3'd6;
  localparam logic [2:0] SRC_TSP = 3'd7;

  // Program steps.
  localparam logic [3:0] STEP_WAIT = 4'd0;
  localparam logic [3:0] STEP_PREP = 4'd1;
  localparam logic [3:0] STEP_DABBLE = 4'd2;
  localparam logic [3:0] STEP_EXTRACT = 4'd3;
  localparam logic [3:0] STEP_LAYOUT = 4'd4;
  localparam logic [3:0] STEP_LSP = 4'd5;
  localparam logic [3:0] STEP_SIGN = 4'd6;
  localparam logic [3:0] STEP_PRE0 = 4'd7;
  localparam logic [3:0] STEP_PREX = 4'd8;
  localparam logic [3:0] STEP_ZPAD = 4'd9;
  localparam logic [3:0] STEP_PREC = 4'd10;
  localparam logic [3:0] STEP_DIG = 4'd11;
  localparam logic [3:0] STEP_TSP = 4'd12;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] src;
    logic [3:0] nxt;
    logic [3:0] alt;
  } ucode_t;

  // The control store: one word per program step.
  function automatic ucode_t ucode(input logic [3:0] step);
    ucode_t w;
    case (step)
      STEP_WAIT:    w = '{OP_WAIT,    SRC_LSP,  STEP_PREP,    STEP_WAIT};
      STEP_PREP:    w = '{OP_PREP,    SRC_LSP,  STEP_DABBLE,  STEP_EXTRACT};
      STEP_DABBLE:  w = '{OP_DABBLE,  SRC_LSP,  STEP_EXTRACT, STEP_WAIT};
      STEP_EXTRACT: w = '{OP_EXTRACT, SRC_LSP,  STEP_LAYOUT,  STEP_WAIT};
      STEP_LAYOUT:  w = '{OP_LAYOUT,  SRC_LSP,  STEP_LSP,     STEP_WAIT};
      STEP_LSP:     w = '{OP_EMIT,    SRC_LSP,  STEP_SIGN,    STEP_WAIT};
      STEP_SIGN:    w = '{OP_EMIT,    SRC_SIGN, STEP_PRE0,    STEP_WAIT};
      STEP_PRE0:    w = '{OP_EMIT,    SRC_PRE0, STEP_PREX,    STEP_WAIT};
      STEP_PREX:    w = '{OP_EMIT,    SRC_PREX, STEP_ZPAD,    STEP_WAIT};
      STEP_ZPAD:    w = '{OP_EMIT,    SRC_ZPAD, STEP_PREC,    STEP_WAIT};
      STEP_PREC:    w = '{OP_EMIT,    SRC_PREC, STEP_DIG,     STEP_WAIT};
      STEP_DIG:     w = '{OP_EMIT,    SRC_DIG,  STEP_TSP,     STEP_WAIT};
      STEP_TSP:     w = '{OP_EMIT,    SRC_TSP,  STEP_WAIT,    STEP_WAIT};
      default:      w = '{OP_WAIT,    SRC_LSP,  STEP_WAIT,    STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = (upper ? CH_UP_A : CH_LOW_A) + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/integer_to_ascii_formatter_core.sv
// Steps: the magnitude is taken, a shift-and-adjust pass over all 64 bits follows
// for decimal only, the number is split one digit at a time (1 to 22 digits), a
// layout step follows, then the characters go out one by one through the eight text
// segments, held while the output is not taken. One number is handled at a time.
// Reset (rst, synchronous, active high) returns the sequencer to its wait step and
// empties the output register.
`default_nettype none
module integer_to_ascii_formatter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: value[63:0], base_sel[65:64], text_width[72:66],
  // min_digits[79:73], format_flags[86:80], zero fill[87].
  input  wire logic [itaf_pkg::IN_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // Fields from bit 0: out_char[7:0].
  output logic [7:0]                         m_tdata,
  // is_last: high on the final character of the number.
  output logic                               m_tlast
);
  import itaf_pkg::*;

  // The sequencer: a step counter addresses the control store, and each control word
  // selects the datapath operation, the character source and the jump targets.
  logic [3:0]       step;
  ucode_t           cw;

  // Latched input word.
  logic [VAL_W-1:0] value;
  logic [1:0]       base_sel;
  logic [6:0]       text_width;
  logic [6:0]       min_digits;
  logic [6:0]       format_flags;

  // Number datapath.
  logic [VAL_W-1:0]  mag;
  logic [WORK_W-1:0] work;
  logic [DCNT_W-1:0] dcnt;
  logic [ND_W-1:0]   nd;
  logic [3:0]        rev [0:MAX_DIGITS-1];
  logic              has_sign;
  logic [7:0]        sign_char;
  logic [1:0]        prefix_len;

  // Layout and emit counters.
  logic [CNT_W-1:0] pad;
  logic [CNT_W-1:0] zeros;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] pc;

  logic              left;
  logic              zpad;
  logic              upper;
  logic              is_dec;
  logic              is_oct;
  logic              neg;
  logic [VAL_W-1:0]  mag_next;
  logic [1:0]        prefix_next;
  logic [WORK_W-1:0] adj;
  logic [3:0]        digit;
  logic [WORK_W-1:0] work_shifted;
  logic signed [7:0] width_s;
  logic signed [7:0] prec_s;
  logic signed [7:0] dlen_s;
  logic signed [7:0] pad_s;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  idx_full;
  logic [IDX_W-1:0]  idx;
  logic [7:0]        ch;
  logic              out_free;
  logic              emit_ok;
  logic              phase_done;

  assign cw       = ucode(step);
  assign s_tready = (cw.op == OP_WAIT);
  assign left     = format_flags[FLAG_LEFT];
  assign zpad     = !left && format_flags[FLAG_ZPAD];
  assign upper    = format_flags[FLAG_UPPER];
  assign is_dec   = (base_sel == BASE_DEC);
  assign is_oct   = (base_sel == BASE_OCT);

  // Sign, magnitude and radix prefix of the latched number.
  always_comb begin
    neg      = format_flags[FLAG_SIGNED] && value[VAL_W-1];
    mag_next = neg ? (~value + {{(VAL_W-1){1'b0}}, 1'b1}) : value;
    if (format_flags[FLAG_PREFIX] && (mag_next != '0) && !is_dec) begin
      prefix_next = is_oct ? 2'd1 : 2'd2;
    end else begin
      prefix_next = 2'd0;
    end
  end

  // Binary to BCD: every decimal digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (work[4*i +: 4] >= 4'd5) ? work[4*i +: 4] + 4'd3 : work[4*i +: 4];
    end
  end

  // Digit split: octal takes three bits at a time, decimal BCD and hex four.
  always_comb begin
    if (is_oct) begin
      digit        = {1'b0, work[2:0]};
      work_shifted = work >> 3;
    end else begin
      digit        = work[3:0];
      work_shifted = work >> 4;
    end
  end

  // Layout: width and precision, negative meaning none, saturated at their caps.
  always_comb begin
    if (text_width[6]) begin
      width_s = -8'sd1;
    end else if (text_width[5:0] > 6'(WIDTH_CAP)) begin
      width_s = 8'(WIDTH_CAP);
    end else begin
      width_s = {2'b00, text_width[5:0]};
    end
    if (min_digits[6]) begin
      prec_s = -8'sd1;
    end else if (min_digits[5:0] > 6'(PREC_CAP)) begin
      prec_s = 8'(PREC_CAP);
    end else begin
      prec_s = {2'b00, min_digits[5:0]};
    end
    dlen_s = ($signed({3'b000, nd}) > prec_s) ? $signed({3'b000, nd}) : prec_s;
    pad_s  = width_s - $signed({7'd0, has_sign}) - $signed({6'd0, prefix_len}) - dlen_s;
    if (pad_s < 0) begin
      pad_s = 8'sd0;
    end
  end

  // Length of the segment that the current emit step prints, and its character.
  always_comb begin
    idx_full = CNT_W'(nd) - CNT_W'(1) - pc;
    idx      = idx_full[IDX_W-1:0];
    case (cw.src)
      SRC_LSP: begin
        cnt = (!left && !zpad) ? pad : '0;
        ch  = CH_SPACE;
      end
      SRC_SIGN: begin
        cnt = CNT_W'(has_sign);
        ch  = sign_char;
      end
      SRC_PRE0: begin
        cnt = CNT_W'(prefix_len != 2'd0);
        ch  = CH_ZERO;
      end
      SRC_PREX: begin
        cnt = CNT_W'(prefix_len == 2'd2);
        ch  = upper ? CH_UP_X : CH_LOW_X;
      end
      SRC_ZPAD: begin
        cnt = zpad ? pad : '0;
        ch  = CH_ZERO;
      end
      SRC_PREC: begin
        cnt = zeros;
        ch  = CH_ZERO;
      end
      SRC_DIG: begin
        cnt = CNT_W'(nd);
        ch  = digit_char(rev[idx], upper);
      end
      default: begin
        cnt = left ? pad : '0;
        ch  = CH_SPACE;
      end
    endcase
    out_free   = !m_tvalid || m_tready;
    phase_done = (cw.op == OP_EMIT) && (pc == cnt);
    emit_ok    = (cw.op == OP_EMIT) && (pc != cnt) && out_free;
  end

  // Sequencer and control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
      rem  <= '0;
      pc   <= '0;
    end else begin
      case (cw.op)
        OP_WAIT: begin
          if (s_tvalid) begin
            step <= cw.nxt;
          end
        end
        OP_PREP: begin
          step <= is_dec ? cw.nxt : cw.alt;
        end
        OP_DABBLE: begin
          if (dcnt == DCNT_W'(VAL_W - 1)) begin
            step <= cw.nxt;
          end
        end
        OP_EXTRACT: begin
          if (work_shifted == '0) begin
            step <= cw.nxt;
          end
        end
        OP_LAYOUT: begin
          rem  <= CNT_W'(pad_s) + CNT_W'(has_sign) + CNT_W'(prefix_len) + CNT_W'(dlen_s);
          pc   <= '0;
          step <= cw.nxt;
        end
        OP_EMIT: begin
          if (phase_done) begin
            pc   <= '0;
            step <= cw.nxt;
          end else if (emit_ok) begin
            pc  <= pc + CNT_W'(1);
            rem <= rem - CNT_W'(1);
          end
        end
        default: begin
          step <= STEP_WAIT;
        end
      endcase
    end
  end

  // Number datapath registers.
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_WAIT: begin
        if (s_tvalid) begin
          value        <= s_tdata[63:0];
          base_sel     <= s_tdata[65:64];
          text_width   <= s_tdata[72:66];
          min_digits   <= s_tdata[79:73];
          format_flags <= s_tdata[86:80];
        end
      end
      OP_PREP: begin
        mag        <= mag_next;
        has_sign   <= format_flags[FLAG_SIGNED] &&
                      (value[VAL_W-1] || format_flags[FLAG_PLUS] || format_flags[FLAG_SPACE]);
        sign_char  <= value[VAL_W-1] ? CH_MINUS :
                      (format_flags[FLAG_PLUS] ? CH_PLUS : CH_SPACE);
        prefix_len <= prefix_next;
        work       <= is_dec ? '0 : WORK_W'(mag_next);
        dcnt       <= '0;
        nd         <= '0;
      end
      OP_DABBLE: begin
        work <= {adj[WORK_W-2:0], mag[VAL_W-1]};
        mag  <= mag << 1;
        dcnt <= dcnt + DCNT_W'(1);
      end
      OP_EXTRACT: begin
        work <= work_shifted;
        nd   <= nd + ND_W'(1);
      end
      OP_LAYOUT: begin
        pad   <= CNT_W'(pad_s);
        zeros <= CNT_W'(dlen_s) - CNT_W'(nd);
      end
      default: begin
      end
    endcase
  end

  // Digit store, filled least significant digit first.
  always_ff @(posedge clk) begin
    if (cw.op == OP_EXTRACT) begin
      rev[nd[IDX_W-1:0]] <= digit;
    end
  end

  // Output register: the next character may be loaded while the present one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_ok) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      m_tdata <= ch;
      m_tlast <= (rem == CNT_W'(1));
    end
  end

  // A character is never emitted once the count of the text has run out.
  a_no_extra_char: assert property (@(posedge clk) disable iff (rst)
    emit_ok |-> (rem != '0))
    else $error("character emitted beyond end of text");

  // Every character of a number has been loaded into the output register by the time the sequencer waits again.
  a_text_complete: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_WAIT) |-> (rem == '0))
    else $error("sequencer idle with characters outstanding");

  // The digit split never runs past the digit store.
  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EXTRACT) |-> (nd < ND_W'(MAX_DIGITS)))
    else $error("digit store overrun");

  // An accepted number is followed by the magnitude step.
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (step == STEP_PREP))
    else $error("accepted number not taken to the magnitude step");

endmodule
`default_nettype wire

FILE: dv/itaf_text_checker.sv
`default_nettype none
module itaf_text_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  input  wire logic                      s_tready,
  input  wire logic [itaf_pkg::IN_W-1:0] s_tdata,
  input  wire logic                      m_tvalid,
  input  wire logic                      m_tready,
  input  wire logic [7:0]                m_tdata,
  input  wire logic                      m_tlast,
  output int                             mismatch_count,
  output int                             chars_pending
);
  import itaf_pkg::*;

  localparam logic [7:0] ASCII_ZERO = "0";
  localparam logic [7:0] ASCII_SPACE = " ";
  localparam logic [7:0] ASCII_MINUS = "-";
  localparam logic [7:0] ASCII_PLUS = "+";
  localparam logic [7:0] ASCII_LOW_A = "a";
  localparam logic [7:0] ASCII_UP_A = "A";
  localparam logic [7:0] ASCII_LOW_X = "x";
  localparam logic [7:0] ASCII_UP_X = "X";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t pending_text[$];
  int errors = 0;

  // Lays out one number as printf would and queues its characters.
  function automatic void format_number(input logic [IN_W-1:0] word);
    logic [63:0] mag;
    logic [1:0]  base_sel;
    logic [6:0]  fw_raw;
    logic [6:0]  md_raw;
    logic [6:0]  flags;
    logic [4:0]  radix;
    logic [7:0]  dig;
    logic [7:0]  sign_ch;
    logic [7:0]  rev[24];
    logic [7:0]  text[$];
    logic        left;
    logic        zpad;
    logic        upper;
    text_char_t  item;
    int width, prec, nd, digits_len, pad, prefix_len, sign_len, n;
    mag = word[63:0];
    base_sel = word[65:64];
    fw_raw = word[72:66];
    md_raw = word[79:73];
    flags = word[86:80];
    width = fw_raw[6] ? -1 : int'(fw_raw[5:0]);
    prec = md_raw[6] ? -1 : (md_raw[5:0] > PREC_CAP ? PREC_CAP : int'(md_raw[5:0]));
    if (width > WIDTH_CAP) width = WIDTH_CAP;
    radix = (base_sel == BASE_OCT) ? 5'd8 : ((base_sel == BASE_DEC) ? 5'd10 : 5'd16);
    upper = flags[FLAG_UPPER];
    left = flags[FLAG_LEFT];
    zpad = !left && flags[FLAG_ZPAD];

    sign_len = 0;
    sign_ch = ASCII_SPACE;
    if (flags[FLAG_SIGNED]) begin
      if (mag[63]) begin
        sign_ch = ASCII_MINUS;
        mag = 64'd0 - mag;
        sign_len = 1;
      end else if (flags[FLAG_PLUS]) begin
        sign_ch = ASCII_PLUS;
        sign_len = 1;
      end else if (flags[FLAG_SPACE]) begin
        sign_ch = ASCII_SPACE;
        sign_len = 1;
      end
    end

    prefix_len = 0;
    if (flags[FLAG_PREFIX] && mag != 64'd0) begin
      if (radix == 5'd16) prefix_len = 2;
      else if (radix == 5'd8) prefix_len = 1;
    end

    nd = 0;
    if (mag == 64'd0) begin
      rev[0] = ASCII_ZERO;
      nd = 1;
    end else begin
      while (mag != 64'd0) begin
        dig = 8'(mag % radix);
        rev[nd] = (dig < 8'd10) ? ASCII_ZERO + dig
                                : (upper ? ASCII_UP_A : ASCII_LOW_A) + dig - 8'd10;
        mag = mag / radix;
        nd++;
      end
    end
    digits_len = (nd > prec) ? nd : prec;
    pad = width - sign_len - prefix_len - digits_len;
    if (pad < 0) pad = 0;

    if (!left && !zpad)
      for (int i = 0; i < pad; i++) text.push_back(ASCII_SPACE);
    if (sign_len != 0) text.push_back(sign_ch);
    if (prefix_len >= 1) text.push_back(ASCII_ZERO);
    if (prefix_len == 2) text.push_back(upper ? ASCII_UP_X : ASCII_LOW_X);
    if (zpad)
      for (int i = 0; i < pad; i++) text.push_back(ASCII_ZERO);
    for (int i = nd; i < digits_len; i++) text.push_back(ASCII_ZERO);
    for (int i = nd - 1; i >= 0; i--) text.push_back(rev[i]);
    if (left)
      for (int i = 0; i < pad; i++) text.push_back(ASCII_SPACE);

    n = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
    for (int i = 0; i < n; i++) begin
      item.ch = text[i];
      item.last = (i == n - 1);
      pending_text.push_back(item);
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    if (errors < 10)
      $display("%0t: %s differs: expected %h, got %h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    text_char_t head;
    if (!rst) begin
      if (s_tvalid && s_tready) format_number(s_tdata);
      if (m_tvalid && m_tready) begin
        if (pending_text.size() == 0) begin
          if (errors < 10)
            $display("%0t: character %h (last %b) with nothing expected",
                     $time, m_tdata, m_tlast);
          errors++;
        end else begin
          head = pending_text.pop_front();
          if (m_tdata !== head.ch) note_mismatch("character", head.ch, m_tdata);
          if (m_tlast !== head.last) note_mismatch("last flag", 8'(head.last), 8'(m_tlast));
        end
      end
    end
    mismatch_count <= errors;
    chars_pending <= pending_text.size();
  end

endmodule
`default_nettype wire

FILE: dv/tb_integer_to_ascii_formatter_core.sv
`default_nettype none
module tb_integer_to_ascii_formatter_core;
  import itaf_pkg::*;

  // Radix codes that the package does not name. Code three is an alias
  // of hexadecimal and is exercised once in the directed part.
  localparam logic [1:0] BASE_HEX = 2'd2;
  localparam logic [1:0] BASE_ALT_HEX = 2'd3;

  // Flag masks, one bit each, built from the package bit positions.
  localparam logic [6:0] F_ZPAD = 7'(1 << FLAG_ZPAD);
  localparam logic [6:0] F_SIGNED = 7'(1 << FLAG_SIGNED);
  localparam logic [6:0] F_PLUS = 7'(1 << FLAG_PLUS);
  localparam logic [6:0] F_SPACE = 7'(1 << FLAG_SPACE);
  localparam logic [6:0] F_LEFT = 7'(1 << FLAG_LEFT);
  localparam logic [6:0] F_PREFIX = 7'(1 << FLAG_PREFIX);
  localparam logic [6:0] F_UPPER = 7'(1 << FLAG_UPPER);

  localparam int NO_LEN = -1;
  localparam int RANDOM_PHASES = 4;
  localparam int WORDS_PER_PHASE = 50;
  // A decimal number runs its whole shift-and-adjust pass before its first
  // character and each side may stall at random, but the limit lies well
  // beyond both, so reaching it can only mean that the block has hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last expected character, in case the block
  // still emits something it should not.
  localparam int SETTLE_CYCLES = 200;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // Fields from bit 0: value[63:0], base_sel[65:64], text_width[72:66],
  // min_digits[79:73], format_flags[86:80], zero fill[87].
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // Fields from bit 0: out_char[7:0].
  logic [7:0]          m_tdata;
  logic                m_tlast;

  int mismatch_count;
  int chars_pending;

  // While this is set neither side idles, so the block runs back to back.
  logic no_idle = 1'b0;
  int   ready_hold = 0;
  int   idle_cycles = 0;

  integer_to_ascii_formatter_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  itaf_text_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle lengths: most gaps are absent or a few cycles long, and now and
  // then a long one lets the other side run dry or fill up.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver stalls at random; a stall is held for a whole run of
  // cycles so that it can land on any character of a number.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      ready_hold <= pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which no word crosses either channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("integer_to_ascii_formatter_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [IN_W-1:0] pack_number(input logic [63:0] value,
                                                  input logic [1:0] base_sel,
                                                  input int text_width,
                                                  input int min_digits,
                                                  input logic [6:0] flags);
    return {1'b0, flags, 7'(min_digits), 7'(text_width), base_sel, value};
  endfunction

  // Offers one number and holds it until the block takes it. The valid is
  // only lowered when a gap follows, so back-to-back words keep it high.
  task automatic send_number(input logic [IN_W-1:0] word);
    int gap;
    s_tdata <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender back until every expected character has come out.
  // The extra edge lets the checker's count catch up with the last word.
  task automatic drain_block();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  // Random numbers lean towards the interesting: short values, values
  // of random bit length, the extremes, and negatives for signed output.
  // Width and precision are mostly absent or small, now and then large.
  function automatic logic [IN_W-1:0] random_number();
    logic [63:0] value;
    int fw;
    int md;
    case ($urandom_range(0, 4))
      0: value = {$urandom, $urandom};
      1: value = 64'($urandom_range(0, 1000));
      2: value = 64'd0 - 64'($urandom_range(1, 100000));
      3: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: begin
        case ($urandom_range(0, 3))
          0: value = 64'd0;
          1: value = '1;
          2: value = 64'h8000_0000_0000_0000;
          default: value = 64'h7fff_ffff_ffff_ffff;
        endcase
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: fw = NO_LEN;
      9: fw = $urandom_range(25, 63);
      default: fw = $urandom_range(0, 24);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: md = NO_LEN;
      9: md = $urandom_range(25, 63);
      default: md = $urandom_range(0, 24);
    endcase
    return pack_number(value, 2'($urandom_range(0, 2)), fw, md, 7'($urandom_range(0, 127)));
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: zero in each radix, the extremes of the value, every
    // sign rule, prefix dropping, the left-justify-over-zero-pad rule, the
    // alias radix code and the saturation of precision.
    send_number(pack_number(64'd0, BASE_DEC, NO_LEN, NO_LEN, 7'd0));
    send_number(pack_number(64'd0, BASE_HEX, 10, 0, F_PREFIX | F_ZPAD));
    send_number(pack_number('1, BASE_OCT, NO_LEN, NO_LEN, F_PREFIX));
    send_number(pack_number(64'h8000_0000_0000_0000, BASE_DEC, NO_LEN, NO_LEN, F_SIGNED));
    send_number(pack_number('1, BASE_DEC, 63, NO_LEN, F_SIGNED | F_ZPAD));
    send_number(pack_number(64'd12345, BASE_DEC, 8, NO_LEN, F_SIGNED | F_PLUS));
    send_number(pack_number(64'd12345, BASE_DEC, 8, NO_LEN, F_SIGNED | F_SPACE));
    send_number(pack_number(64'd12345, BASE_DEC, NO_LEN, NO_LEN,
                            F_SIGNED | F_PLUS | F_SPACE));
    send_number(pack_number(64'd12345, BASE_DEC, 8, NO_LEN, F_PLUS | F_SPACE));
    send_number(pack_number(64'hdead_beef, BASE_HEX, 20, NO_LEN,
                            F_LEFT | F_ZPAD | F_PREFIX));
    send_number(pack_number(64'hdead_beef, BASE_HEX, 63, 63,
                            F_PREFIX | F_UPPER | F_SIGNED | F_PLUS));
    send_number(pack_number('1, BASE_ALT_HEX, 63, 60, F_PREFIX | F_SIGNED));
    send_number(pack_number(64'd42, BASE_DEC, NO_LEN, 5, F_PREFIX));
    send_number(pack_number(64'd1, BASE_OCT, 4, 5, F_PREFIX | F_LEFT));
    send_number(pack_number('1, BASE_HEX, NO_LEN, NO_LEN, F_UPPER | F_PREFIX));
    send_number(pack_number(64'h7fff_ffff_ffff_ffff, BASE_DEC, 0, 0,
                            F_SIGNED | F_SPACE | F_ZPAD));
    send_number(pack_number(64'd0, BASE_OCT, 63, 60, F_SIGNED | F_PLUS | F_LEFT));
    send_number(pack_number(64'h0123_4567_89ab_cdef, BASE_HEX, 30, 20,
                            F_ZPAD | F_SIGNED | F_SPACE | F_PREFIX));
    send_number(pack_number(64'd7, BASE_OCT, 5, NO_LEN, F_ZPAD | F_PREFIX));
    send_number(pack_number(64'd0 - 64'd255, BASE_HEX, 12, 4,
                            F_SIGNED | F_LEFT | F_PREFIX));
    send_number(pack_number(64'h5555_5555_5555_5555, BASE_HEX, 40, 61,
                            F_UPPER | F_ZPAD | F_PREFIX));
    drain_block();

    // Random part in phases. The sender waits for the block to empty
    // between phases, and one phase runs with no idling on either side.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle = (phase == 2);
      for (int k = 0; k < WORDS_PER_PHASE; k++) send_number(random_number());
      drain_block();
    end
    no_idle = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("integer_to_ascii_formatter_core: match");
    end else begin
      $display("integer_to_ascii_formatter_core: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
src/itaf_pkg.sv
src/integer_to_ascii_formatter_core.sv
dv/itaf_text_checker.sv
dv/tb_integer_to_ascii_formatter_core.sv
